// ===== hw/rtl/shs_pkg.sv =====
// shared types, round constants and initial hash values for the sha-256 stream hasher
package shs_pkg;

	typedef logic [31:0] word_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] CNT_LAST = 6'd63;
	localparam logic [5:0] ROUND_LAST = 6'd63;

	localparam word_t K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t IV_TAB [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_START,
		ST_WAIT,
		ST_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		CP_IDLE,
		CP_ROUND,
		CP_ADD
	} core_phase_t;

	typedef struct packed {
		logic       load;
		logic [7:0] data;
		logic       start;
		logic       reinit;
	} core_ctrl_t;

	typedef struct packed {
		logic         done;
		logic [255:0] digest;
	} core_stat_t;

endpackage

// ===== hw/rtl/sha256_stream_hasher.sv =====
// sha-256 stream hasher: byte input channel, 256-bit digest output channel
//
// Input channel (in_valid/in_ready): one message byte per transaction in data_byte,
// qualified by byte_present; end_of_message closes the message after that byte.
// An end mark with no byte and nothing pending hashes the empty message.
// Output channel (out_valid/out_ready): one digest per message as four 64-bit
// big-endian parts, digest_part_0 holding hash words 0 and 1.
// A byte that does not complete a 64-byte block is taken without a stall. The
// byte that completes a block starts a compression on the shared round unit: a
// start step, 64 rounds and a step to add into the hash. After an end mark the
// sequencer feeds the 0x80 mark, zeros and the bit length one byte per cycle
// (over two blocks when the mark lands past byte 55) with a compression after
// each padded block. in_ready is low during each compression and the padding.
// The digest goes into an output register; if the previous digest has not been
// taken yet, the block waits with in_ready low until out_ready frees it.
// Reset returns the hash to its initial values and drops any partial message.
module sha256_stream_hasher
	import shs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_part_0,
	output logic [63:0] digest_part_1,
	output logic [63:0] digest_part_2,
	output logic [63:0] digest_part_3
);

	seq_state_t   state_q, state_d;
	logic [5:0]   cnt_q;
	logic [63:0]  bits_q;
	logic         end_q;
	logic         mark_q;
	logic         lenblk_q;
	logic         lendone_q;
	logic         out_valid_q;
	logic [255:0] digest_q;
	logic [7:0]   pad_byte;
	logic         in_acc;
	logic         out_load;
	core_ctrl_t   ctrl;
	core_stat_t   stat;

	shs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat)
	);

	always_comb begin
		if (!mark_q) begin
			pad_byte = PAD_MARK;
		end else if (lenblk_q && cnt_q >= LEN_POS) begin
			// length bytes go out most significant first
			pad_byte = bits_q[{~cnt_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_load    = 1'b0;
		ctrl.load   = 1'b0;
		ctrl.data   = pad_byte;
		ctrl.start  = 1'b0;
		ctrl.reinit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ctrl.data = data_byte;
				ctrl.load = in_valid && byte_present;
				if (in_valid) begin
					if (byte_present && cnt_q == CNT_LAST) begin
						state_d = ST_START;
					end else if (end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				ctrl.load = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				ctrl.start = 1'b1;
				state_d    = ST_WAIT;
			end
			ST_WAIT: begin
				if (stat.done) begin
					if (lendone_q) begin
						state_d = ST_DONE;
					end else if (end_q) begin
						state_d = ST_PAD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load    = 1'b1;
					ctrl.reinit = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			bits_q    <= '0;
			end_q     <= 1'b0;
			mark_q    <= 1'b0;
			lenblk_q  <= 1'b0;
			lendone_q <= 1'b0;
		end else if (out_load) begin
			cnt_q     <= '0;
			bits_q    <= '0;
			end_q     <= 1'b0;
			mark_q    <= 1'b0;
			lenblk_q  <= 1'b0;
			lendone_q <= 1'b0;
		end else begin
			if (in_acc) begin
				end_q <= end_of_message;
				if (byte_present) begin
					cnt_q  <= cnt_q + 6'd1;
					bits_q <= bits_q + 64'd8;
				end
			end
			if (state_q == ST_PAD) begin
				cnt_q  <= cnt_q + 6'd1;
				mark_q <= 1'b1;
				// mark early enough: the length fits in this block
				if (!mark_q && cnt_q < LEN_POS) begin
					lenblk_q <= 1'b1;
				end
				if (cnt_q == CNT_LAST) begin
					lendone_q <= lenblk_q;
				end
			end
			if (state_q == ST_WAIT && stat.done && end_q) begin
				lenblk_q <= mark_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			digest_q <= stat.digest;
		end
	end

	assign out_valid     = out_valid_q;
	assign digest_part_0 = digest_q[255:192];
	assign digest_part_1 = digest_q[191:128];
	assign digest_part_2 = digest_q[127:64];
	assign digest_part_3 = digest_q[63:0];

endmodule

// ===== hw/rtl/shs_core.sv =====
// sha-256 block buffer, rolling message schedule and one-round-per-cycle compression unit
module shs_core
	import shs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  core_ctrl_t ctrl,
	output core_stat_t stat
);

	logic [511:0] win_q;
	word_t        wk_q [8];
	word_t        hash_q [8];
	core_phase_t  phase_q, phase_d;
	logic [5:0]   round_q;

	word_t w0, w1, w9, w14, w_new;
	word_t t1, t2, ch, maj;

	function automatic word_t rotr(word_t v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	always_comb begin
		// word j of the window sits at bits 511-32j down
		w0  = win_q[511:480];
		w1  = win_q[479:448];
		w9  = win_q[223:192];
		w14 = win_q[63:32];
		w_new = w0 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w9
			+ (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10));
		ch  = (wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]);
		maj = (wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]);
		t1 = wk_q[7] + (rotr(wk_q[4], 6) ^ rotr(wk_q[4], 11) ^ rotr(wk_q[4], 25))
			+ ch + K_TAB[round_q] + w0;
		t2 = (rotr(wk_q[0], 2) ^ rotr(wk_q[0], 13) ^ rotr(wk_q[0], 22)) + maj;
	end

	// bytes shift in big-endian; rounds slide the window one word
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			win_q <= {win_q[503:0], ctrl.data};
		end else if (phase_q == CP_ROUND) begin
			win_q <= {win_q[479:0], w_new};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			wk_q <= hash_q;
		end else if (phase_q == CP_ROUND) begin
			wk_q[7] <= wk_q[6];
			wk_q[6] <= wk_q[5];
			wk_q[5] <= wk_q[4];
			wk_q[4] <= wk_q[3] + t1;
			wk_q[3] <= wk_q[2];
			wk_q[2] <= wk_q[1];
			wk_q[1] <= wk_q[0];
			wk_q[0] <= t1 + t2;
		end
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			CP_IDLE: begin
				if (ctrl.start) begin
					phase_d = CP_ROUND;
				end
			end
			CP_ROUND: begin
				if (round_q == ROUND_LAST) begin
					phase_d = CP_ADD;
				end
			end
			CP_ADD: begin
				phase_d = CP_IDLE;
			end
			default: begin
				phase_d = CP_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= CP_IDLE;
			round_q <= '0;
			hash_q  <= IV_TAB;
		end else begin
			phase_q <= phase_d;
			// wraps back to zero after the last round
			if (phase_q == CP_ROUND) begin
				round_q <= round_q + 6'd1;
			end
			if (ctrl.reinit) begin
				hash_q <= IV_TAB;
			end else if (phase_q == CP_ADD) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + wk_q[i];
				end
			end
		end
	end

	assign stat.done   = (phase_q == CP_ADD);
	assign stat.digest = {hash_q[0], hash_q[1], hash_q[2], hash_q[3],
		hash_q[4], hash_q[5], hash_q[6], hash_q[7]};

endmodule

// ===== hw/rtl/shs_checker.sv =====
// port-level checks for the sha-256 stream hasher, bound to the top level
module shs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        end_of_message,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] digest_part_0
);

	// a pending digest is held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_part_0))
		else $error("digest dropped or changed while stalled");

	// an end mark always leads into padding, never straight back to idle
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_message |=> !in_ready)
		else $error("input ready right after an end-of-message transaction");

	// a new digest only appears while the input side is held off
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("digest appeared while input was ready");

	// the input side is closed before a digest is loaded and ready again once it appears
	a_ready_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready && $past(!in_ready, 2))
		else $error("digest load not framed by the busy sequencer");

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (.*);
